// ----- src/lratc_pkg.sv -----
// Shared types and constants for the LRU address tag cache.
`timescale 1ns / 1ps

package lratc_pkg;

  localparam int KEY_BITS       = 48;
  localparam int IN_VALUE_BITS  = 32;
  localparam int KIND_BITS      = 2;
  localparam int STATUS_BITS    = 2;
  localparam int CFG_BITS       = 7;

  localparam logic [CFG_BITS-1:0] MAX_ENTRIES_RST = 7'd64;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_MISS   = 2'd1,
    STATUS_REJECT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_DECIDE,
    SEQ_UPDATE,
    SEQ_DONE
  } seq_state_t;

  // Rewrite rule applied by the entry unit during an update sweep.
  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_TOUCH,
    UPD_INSERT,
    UPD_DROP
  } upd_mode_t;

  typedef struct packed {
    upd_mode_t mode;
    logic      at_target;
    logic      at_evict;
  } unit_ctl_t;

  typedef struct packed {
    logic match;
    logic free;
    logic oldest;
  } scan_hit_t;

endpackage

// ----- src/lratc_mem.sv -----
// Entry store: one write port, one registered read port.
`timescale 1ns / 1ps

module lratc_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 88
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/lratc_unit.sv -----
// Shared entry unit: key/rank compare for scans, entry rewrite for updates.
`timescale 1ns / 1ps

module lratc_unit #(
  parameter int RANK_BITS  = 6,
  parameter int VALUE_BITS = 32
) (
  input  logic                            e_valid,
  input  logic [RANK_BITS-1:0]            e_rank,
  input  logic [lratc_pkg::KEY_BITS-1:0]  e_key,
  input  logic [VALUE_BITS-1:0]           e_value,
  input  logic [lratc_pkg::KEY_BITS-1:0]  req_key,
  input  logic [VALUE_BITS-1:0]           req_value,
  input  lratc_pkg::unit_ctl_t            ctl,
  input  logic [RANK_BITS-1:0]            rank_ref,
  input  logic [RANK_BITS-1:0]            old_rank,
  output lratc_pkg::scan_hit_t            hit,
  output logic                            w_valid,
  output logic [RANK_BITS-1:0]            w_rank,
  output logic [lratc_pkg::KEY_BITS-1:0]  w_key,
  output logic [VALUE_BITS-1:0]           w_value
);

  import lratc_pkg::*;

  always_comb begin
    hit.match  = e_valid && (e_key == req_key);
    hit.free   = !e_valid;
    hit.oldest = e_valid && (e_rank == old_rank);
  end

  always_comb begin
    w_valid = e_valid;
    w_rank  = e_rank;
    w_key   = e_key;
    w_value = e_value;
    case (ctl.mode)
      UPD_TOUCH: begin
        // hit entry to front, younger ones age by one
        if (ctl.at_target) begin
          w_rank = '0;
        end else if (e_valid && (e_rank < rank_ref)) begin
          w_rank = e_rank + RANK_BITS'(1);
        end
      end
      UPD_INSERT: begin
        if (ctl.at_target) begin
          w_valid = 1'b1;
          w_rank  = '0;
          w_key   = req_key;
          w_value = req_value;
        end else if (ctl.at_evict) begin
          w_valid = 1'b0;
        end else if (e_valid) begin
          w_rank = e_rank + RANK_BITS'(1);
        end
      end
      UPD_DROP: begin
        // close the gap left by the removed rank
        if (ctl.at_target) begin
          w_valid = 1'b0;
        end else if (e_valid && (e_rank > rank_ref)) begin
          w_rank = e_rank - RANK_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/lratc_seq.sv -----
// Request sequencer: clear sweep, scan sweep, decision, update sweep, result word.
`timescale 1ns / 1ps

module lratc_seq #(
  parameter int ENTRIES    = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic [$clog2(ENTRIES+1)-1:0]               limit,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic [lratc_pkg::KIND_BITS-1:0]            in_kind,
  input  logic [lratc_pkg::KEY_BITS-1:0]             in_key,
  input  logic [lratc_pkg::IN_VALUE_BITS-1:0]        in_value,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic [lratc_pkg::STATUS_BITS-1:0]          out_status,
  output logic [lratc_pkg::IN_VALUE_BITS-1:0]        out_found_value,
  output logic                                       mem_we,
  output logic [$clog2(ENTRIES)-1:0]                 mem_waddr,
  output logic [1+$clog2(ENTRIES)+lratc_pkg::KEY_BITS+VALUE_BITS-1:0] mem_wdata,
  output logic [$clog2(ENTRIES)-1:0]                 mem_raddr,
  input  logic [1+$clog2(ENTRIES)+lratc_pkg::KEY_BITS+VALUE_BITS-1:0] mem_rdata
);

  import lratc_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES+1);
  localparam int RB = AW;
  localparam int NW = AW + 1;
  localparam int WW = 1 + RB + KEY_BITS + VALUE_BITS;
  localparam logic [NW-1:0] LAST = NW'(ENTRIES);

  seq_state_t              state_r, state_nxt;
  logic [NW-1:0]           cnt_r, cnt_nxt;
  logic [KIND_BITS-1:0]    req_kind_r, req_kind_nxt;
  logic [KEY_BITS-1:0]     req_key_r, req_key_nxt;
  logic [VALUE_BITS-1:0]   req_value_r, req_value_nxt;
  logic                    match_found_r, match_found_nxt;
  logic [AW-1:0]           match_idx_r, match_idx_nxt;
  logic [RB-1:0]           match_rank_r, match_rank_nxt;
  logic [VALUE_BITS-1:0]   match_val_r, match_val_nxt;
  logic                    free_found_r, free_found_nxt;
  logic [AW-1:0]           free_idx_r, free_idx_nxt;
  logic [AW-1:0]           old_idx_r, old_idx_nxt;
  upd_mode_t               mode_r, mode_nxt;
  logic [AW-1:0]           tgt_idx_r, tgt_idx_nxt;
  logic                    tgt_ok_r, tgt_ok_nxt;
  logic                    evict_r, evict_nxt;
  logic [RB-1:0]           rank_ref_r, rank_ref_nxt;
  status_t                 status_r, status_nxt;
  logic [VALUE_BITS-1:0]   found_r, found_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [IN_VALUE_BITS-1:0] out_found_r, out_found_nxt;

  logic [AW-1:0]           proc_idx;
  logic                    e_valid;
  logic [RB-1:0]           e_rank;
  logic [KEY_BITS-1:0]     e_key;
  logic [VALUE_BITS-1:0]   e_value;
  logic                    w_valid;
  logic [RB-1:0]           w_rank;
  logic [KEY_BITS-1:0]     w_key;
  logic [VALUE_BITS-1:0]   w_value;
  logic [RB-1:0]           old_rank;
  unit_ctl_t               ctl;
  scan_hit_t               hit;
  logic                    need_evict;
  logic                    ins_ok;
  logic [AW-1:0]           ins_slot;

  // entry word: {valid, rank, key, value}
  assign e_valid  = mem_rdata[WW-1];
  assign e_rank   = mem_rdata[WW-2 -: RB];
  assign e_key    = mem_rdata[VALUE_BITS +: KEY_BITS];
  assign e_value  = mem_rdata[VALUE_BITS-1:0];
  assign proc_idx = AW'(cnt_r - NW'(1));
  assign old_rank = RB'(count_r - CW'(1));

  assign need_evict = ({1'b0, count_r} + (CW+1)'(1)) > {1'b0, limit};
  assign ins_ok     = need_evict || free_found_r;
  assign ins_slot   = need_evict ?
                      ((free_found_r && (free_idx_r < old_idx_r)) ? free_idx_r : old_idx_r) :
                      free_idx_r;

  lratc_unit #(
    .RANK_BITS  (RB),
    .VALUE_BITS (VALUE_BITS)
  ) u_unit (
    .e_valid   (e_valid),
    .e_rank    (e_rank),
    .e_key     (e_key),
    .e_value   (e_value),
    .req_key   (req_key_r),
    .req_value (req_value_r),
    .ctl       (ctl),
    .rank_ref  (rank_ref_r),
    .old_rank  (old_rank),
    .hit       (hit),
    .w_valid   (w_valid),
    .w_rank    (w_rank),
    .w_key     (w_key),
    .w_value   (w_value)
  );

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    req_kind_nxt    = req_kind_r;
    req_key_nxt     = req_key_r;
    req_value_nxt   = req_value_r;
    match_found_nxt = match_found_r;
    match_idx_nxt   = match_idx_r;
    match_rank_nxt  = match_rank_r;
    match_val_nxt   = match_val_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    old_idx_nxt     = old_idx_r;
    mode_nxt        = mode_r;
    tgt_idx_nxt     = tgt_idx_r;
    tgt_ok_nxt      = tgt_ok_r;
    evict_nxt       = evict_r;
    rank_ref_nxt    = rank_ref_r;
    status_nxt      = status_r;
    found_nxt       = found_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_found_nxt   = out_found_r;

    in_stall      = (state_r != SEQ_IDLE);
    mem_we        = 1'b0;
    mem_waddr     = proc_idx;
    mem_wdata     = {w_valid, w_rank, w_key, w_value};
    mem_raddr     = (cnt_r < LAST) ? cnt_r[AW-1:0] : '0;
    ctl.mode      = UPD_NONE;
    ctl.at_target = tgt_ok_r && (proc_idx == tgt_idx_r);
    ctl.at_evict  = evict_r && (proc_idx == old_idx_r);

    case (state_r)
      SEQ_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = '0;
        if (cnt_r == LAST - NW'(1)) begin
          cnt_nxt   = '0;
          state_nxt = SEQ_IDLE;
        end else begin
          cnt_nxt = cnt_r + NW'(1);
        end
      end
      SEQ_IDLE: begin
        if (in_valid) begin
          req_kind_nxt    = in_kind;
          req_key_nxt     = in_key;
          req_value_nxt   = VALUE_BITS'(in_value);
          match_found_nxt = 1'b0;
          free_found_nxt  = 1'b0;
          cnt_nxt         = '0;
          state_nxt       = SEQ_SCAN;
        end
      end
      SEQ_SCAN: begin
        cnt_nxt = cnt_r + NW'(1);
        if (cnt_r != '0) begin
          if (hit.match && !match_found_r) begin
            match_found_nxt = 1'b1;
            match_idx_nxt   = proc_idx;
            match_rank_nxt  = e_rank;
            match_val_nxt   = e_value;
          end
          if (hit.free && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = proc_idx;
          end
          if (hit.oldest) begin
            old_idx_nxt = proc_idx;
          end
        end
        if (cnt_r == LAST) begin
          state_nxt = SEQ_DECIDE;
        end
      end
      SEQ_DECIDE: begin
        cnt_nxt    = '0;
        status_nxt = STATUS_MISS;
        found_nxt  = '0;
        mode_nxt   = UPD_NONE;
        tgt_ok_nxt = 1'b0;
        evict_nxt  = 1'b0;
        state_nxt  = SEQ_DONE;
        case (req_kind_r)
          KIND_LOOKUP: begin
            if (match_found_r) begin
              status_nxt   = STATUS_OK;
              found_nxt    = match_val_r;
              mode_nxt     = UPD_TOUCH;
              tgt_idx_nxt  = match_idx_r;
              tgt_ok_nxt   = 1'b1;
              rank_ref_nxt = match_rank_r;
              state_nxt    = SEQ_UPDATE;
            end
          end
          KIND_INSERT: begin
            if (req_value_r == '0) begin
              status_nxt = STATUS_REJECT;
            end else begin
              status_nxt = STATUS_OK;
              // zero limit on an empty cache: the new entry is gone at once
              if (!match_found_r && !((count_r == '0) && (limit == '0))) begin
                evict_nxt   = need_evict;
                tgt_ok_nxt  = ins_ok;
                tgt_idx_nxt = ins_slot;
                mode_nxt    = UPD_INSERT;
                count_nxt   = count_r - CW'(need_evict) + CW'(ins_ok);
                state_nxt   = SEQ_UPDATE;
              end
            end
          end
          KIND_REMOVE: begin
            if (match_found_r) begin
              status_nxt   = STATUS_OK;
              mode_nxt     = UPD_DROP;
              tgt_idx_nxt  = match_idx_r;
              tgt_ok_nxt   = 1'b1;
              rank_ref_nxt = match_rank_r;
              count_nxt    = count_r - CW'(1);
              state_nxt    = SEQ_UPDATE;
            end
          end
          default: begin
          end
        endcase
      end
      SEQ_UPDATE: begin
        ctl.mode = mode_r;
        cnt_nxt  = cnt_r + NW'(1);
        if (cnt_r != '0) begin
          mem_we = 1'b1;
        end
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_found_nxt  = IN_VALUE_BITS'(found_r);
          state_nxt      = SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= SEQ_CLEAR;
      cnt_r         <= '0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      mode_r        <= UPD_NONE;
      tgt_ok_r      <= 1'b0;
      evict_r       <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
      match_found_r <= match_found_nxt;
      free_found_r  <= free_found_nxt;
      mode_r        <= mode_nxt;
      tgt_ok_r      <= tgt_ok_nxt;
      evict_r       <= evict_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_kind_r   <= req_kind_nxt;
    req_key_r    <= req_key_nxt;
    req_value_r  <= req_value_nxt;
    match_idx_r  <= match_idx_nxt;
    match_rank_r <= match_rank_nxt;
    match_val_r  <= match_val_nxt;
    free_idx_r   <= free_idx_nxt;
    old_idx_r    <= old_idx_nxt;
    tgt_idx_r    <= tgt_idx_nxt;
    rank_ref_r   <= rank_ref_nxt;
    status_r     <= status_nxt;
    found_r      <= found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;

endmodule

// ----- src/lru_address_tag_cache.sv -----
// Top level of the LRU address tag cache: config register, entry store, sequencer.
//
//   channel   direction  handshake             word
//   in_*      input      in_valid / in_stall   kind, key, value
//   out_*     output     out_valid / out_stall status, found_value
//   cfg_*     input      cfg_we                max_entries
//
// Each request runs a scan sweep over all ENTRIES slots through the single read port of
// the entry store, then a decision state and a result state. Misses, rejects and inserts
// of a present key skip the update sweep. Hits, new inserts and removes add an update
// sweep (read-modify-write of every slot) before the result. The sequencer goes back to
// idle before the next word is taken. After reset a clearing pass zeroes every slot of
// the store; in_stall stays high. A finished result word waits in the output register
// while the next request is taken; a second result holds the sequencer in its result
// state until the first is taken.
`timescale 1ns / 1ps

module lru_address_tag_cache #(
  parameter int ENTRIES    = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lratc_pkg::CFG_BITS-1:0]      cfg_max_entries,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lratc_pkg::KIND_BITS-1:0]     in_kind,
  input  logic [lratc_pkg::KEY_BITS-1:0]      in_key,
  input  logic [lratc_pkg::IN_VALUE_BITS-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lratc_pkg::STATUS_BITS-1:0]   out_status,
  output logic [lratc_pkg::IN_VALUE_BITS-1:0] out_found_value
);

  import lratc_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES+1);
  localparam int LW = (CW > CFG_BITS) ? CW : CFG_BITS;
  localparam int WW = 1 + AW + KEY_BITS + VALUE_BITS;

  logic [CFG_BITS-1:0] max_entries_r, max_entries_nxt;
  logic [LW-1:0]       max_ext;
  logic [LW-1:0]       ent_ext;
  logic [CW-1:0]       limit;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [WW-1:0]       mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [WW-1:0]       mem_rdata;

  // capacity register; the user must write it only while the cache is idle, the block does not enforce it
  assign max_entries_nxt = cfg_we ? cfg_max_entries : max_entries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= MAX_ENTRIES_RST;
    end else begin
      max_entries_r <= max_entries_nxt;
    end
  end

  // effective limit never exceeds the slot count
  assign max_ext = LW'(max_entries_r);
  assign ent_ext = LW'(ENTRIES);
  assign limit   = CW'((max_ext < ent_ext) ? max_ext : ent_ext);

  lratc_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (WW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lratc_seq #(
    .ENTRIES    (ENTRIES),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .limit           (limit),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

endmodule

// ----- src/lratc_checker.sv -----
// Port-level checks for the LRU address tag cache, bound to the top level.
`timescale 1ns / 1ps

module lratc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [lratc_pkg::STATUS_BITS-1:0]   out_status,
  input logic [lratc_pkg::IN_VALUE_BITS-1:0] out_found_value
);

  import lratc_pkg::*;

  // reset starts the clearing pass with no result pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("busy/idle state wrong after reset");

  // a request keeps the cache busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken on back-to-back cycles");

  // only a lookup hit carries a value
  a_found_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_OK) |-> out_found_value == '0)
    else $error("nonzero found_value without success status");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_found_value))
    else $error("stalled result word changed");

endmodule

bind lru_address_tag_cache lratc_checker u_lratc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_found_value (out_found_value)
);

// ----- bench/lru_address_tag_cache_tb.sv -----
// Self-checking bench for the LRU address tag cache: directed cases, then random traffic.
`timescale 1ns / 1ps

// Every accepted request word runs through an in-bench copy of the cache (keys, values,
// valid bits, recency ranks, entry count, capacity register). The expected reply goes
// into a FIFO that the checker pops as each result word is taken. The sender works in
// bursts with random gaps. The receiver stalls in segments of its own: free running,
// coin-flip, or solid. The capacity register is only written after the pipe has drained.
module lru_address_tag_cache_tb;
  import lratc_pkg::*;

  localparam int CACHE_SLOTS    = 64;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  // Worst request: scan sweep, decision, update sweep and result, plus margin.
  localparam int SETTLE_CYCLES  = 2 * CACHE_SLOTS + 8;

  // Kind code with no operation behind it; the block must answer it with a miss.
  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

  localparam logic [KEY_BITS-1:0]      KEY_ZERO  = '0;
  localparam logic [KEY_BITS-1:0]      KEY_ONES  = '1;
  localparam logic [IN_VALUE_BITS-1:0] VAL_EMPTY = '0;
  localparam logic [IN_VALUE_BITS-1:0] VAL_ONES  = '1;

  typedef struct {
    status_t                  status;
    logic [IN_VALUE_BITS-1:0] found;
  } cache_reply_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_BITS-1:0]      cfg_max_entries = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [KIND_BITS-1:0]     in_kind = '0;
  logic [KEY_BITS-1:0]      in_key = '0;
  logic [IN_VALUE_BITS-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STATUS_BITS-1:0]   out_status;
  logic [IN_VALUE_BITS-1:0] out_found_value;

  lru_address_tag_cache #(
    .ENTRIES   (CACHE_SLOTS),
    .VALUE_BITS(IN_VALUE_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_max_entries(cfg_max_entries),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_found_value(out_found_value)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Cache shadow. Rank 0 is the most recent entry; valid entries hold 0..count-1.
  // ---------------------------------------------------------------------------
  logic [KEY_BITS-1:0]      shadow_key   [CACHE_SLOTS];
  logic [IN_VALUE_BITS-1:0] shadow_value [CACHE_SLOTS];
  bit                       shadow_valid [CACHE_SLOTS];
  int unsigned              shadow_rank  [CACHE_SLOTS];
  int unsigned              shadow_count = 0;
  int unsigned              capacity_reg = MAX_ENTRIES_RST;

  cache_reply_t expected_replies[$];
  cache_reply_t taken_reply;
  int           fail_count = 0;
  int           burst_left = 0;

  initial begin
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = 0;
    end
  end

  function automatic int find_key(logic [KEY_BITS-1:0] key);
    for (int i = 0; i < CACHE_SLOTS; i++)
      if (shadow_valid[i] && shadow_key[i] == key) return i;
    return -1;
  endfunction

  // Take a slot out and close the gap in the ranks behind it.
  function automatic void drop_entry(int slot);
    int unsigned r;
    r = shadow_rank[slot];
    shadow_valid[slot] = 1'b0;
    for (int i = 0; i < CACHE_SLOTS; i++)
      if (shadow_valid[i] && shadow_rank[i] > r) shadow_rank[i]--;
    if (shadow_count > 0) shadow_count--;
  endfunction

  function automatic void evict_oldest_entry();
    int          victim;
    int unsigned oldest;
    victim = -1;
    oldest = 0;
    for (int i = 0; i < CACHE_SLOTS; i++)
      if (shadow_valid[i] && (victim < 0 || shadow_rank[i] >= oldest)) begin
        oldest = shadow_rank[i];
        victim = i;
      end
    if (victim >= 0) drop_entry(victim);
  endfunction

  function automatic cache_reply_t apply_request(logic [KIND_BITS-1:0] kind,
                                                 logic [KEY_BITS-1:0] key,
                                                 logic [IN_VALUE_BITS-1:0] value);
    cache_reply_t reply;
    int           slot;
    int unsigned  cap;
    int unsigned  r;
    reply.status = STATUS_MISS;
    reply.found  = '0;
    // register above the slot count is clamped
    cap = (capacity_reg < CACHE_SLOTS) ? capacity_reg : CACHE_SLOTS;
    case (kind)
      KIND_LOOKUP: begin
        slot = find_key(key);
        if (slot >= 0) begin
          r = shadow_rank[slot];
          for (int i = 0; i < CACHE_SLOTS; i++)
            if (shadow_valid[i] && shadow_rank[i] < r) shadow_rank[i]++;
          shadow_rank[slot] = 0;
          reply.status = STATUS_OK;
          reply.found  = shadow_value[slot];
        end
      end
      KIND_INSERT: begin
        if (value == VAL_EMPTY) begin
          reply.status = STATUS_REJECT;
        end else if (find_key(key) >= 0) begin
          // present key: old value and order stay
          reply.status = STATUS_OK;
        end else begin
          reply.status = STATUS_OK;
          // zero capacity on an empty cache: the new entry is dropped at once
          if (!(shadow_count == 0 && cap == 0)) begin
            if (shadow_count + 1 > cap) evict_oldest_entry();
            slot = -1;
            for (int i = 0; i < CACHE_SLOTS; i++)
              if (slot < 0 && !shadow_valid[i]) slot = i;
            if (slot >= 0) begin
              for (int i = 0; i < CACHE_SLOTS; i++)
                if (shadow_valid[i]) shadow_rank[i]++;
              shadow_key[slot]   = key;
              shadow_value[slot] = value;
              shadow_valid[slot] = 1'b1;
              shadow_rank[slot]  = 0;
              shadow_count++;
            end
          end
        end
      end
      KIND_REMOVE: begin
        slot = find_key(key);
        if (slot >= 0) begin
          drop_entry(slot);
          reply.status = STATUS_OK;
        end
      end
      default: ;
    endcase
    return reply;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [KEY_BITS-1:0] random_key();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[KEY_BITS-1:0];
  endfunction

  function automatic logic [IN_VALUE_BITS-1:0] random_value();
    int pick;
    pick = $urandom_range(0, 31);
    if (pick == 0) return VAL_EMPTY;
    if (pick == 1) return VAL_ONES;
    return $urandom;
  endfunction

  // Drive one request word and hold it until taken. Bursts of back-to-back words are
  // split by gaps; long gaps let the next word land on any phase of the sweep.
  task automatic send_request(input logic [KIND_BITS-1:0] kind,
                              input logic [KEY_BITS-1:0] key,
                              input logic [IN_VALUE_BITS-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 140) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_key   <= key;
    in_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_replies.push_back(apply_request(kind, key, value));
  endtask

  // Hold off until every reply is in and the sweep has surely finished.
  task automatic drain_pipe();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_BITS-1:0] limit);
    cfg_max_entries <= limit;
    cfg_we          <= 1'b1;
    @(posedge clk);
    cfg_we       <= 1'b0;
    capacity_reg  = limit;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset capacity; miss on empty, reject of the empty handle, extreme keys and values,
  // re-insert keeping the old value, unused kind, remove hit and miss.
  task automatic test_basic_requests();
    send_request(KIND_LOOKUP, KEY_ZERO, VAL_ONES);
    send_request(KIND_INSERT, KEY_ZERO, VAL_EMPTY);
    send_request(KIND_INSERT, KEY_ZERO, VAL_ONES);
    send_request(KIND_INSERT, KEY_ONES, 32'd1);
    send_request(KIND_LOOKUP, KEY_ONES, VAL_EMPTY);
    send_request(KIND_LOOKUP, KEY_ZERO, VAL_ONES);
    send_request(KIND_INSERT, KEY_ZERO, 32'd5);
    send_request(KIND_LOOKUP, KEY_ZERO, VAL_EMPTY);
    send_request(KIND_UNUSED, KEY_ZERO, 32'd7);
    send_request(KIND_REMOVE, KEY_ONES, VAL_ONES);
    send_request(KIND_REMOVE, KEY_ONES, VAL_ONES);
    send_request(KIND_LOOKUP, KEY_ONES, VAL_EMPTY);
  endtask

  // Capacity dropped below the live count: each new insert evicts only the oldest.
  task automatic test_capacity_lowered();
    send_request(KIND_INSERT, 48'h0000_1234_5678, 32'h0000_00a1);
    send_request(KIND_INSERT, 48'h8000_0000_0001, 32'h8000_00a2);
    send_request(KIND_INSERT, 48'h5555_aaaa_5555, 32'h5a5a_a5a5);
    drain_pipe();
    write_capacity(7'd2);
    send_request(KIND_INSERT, 48'haaaa_5555_aaaa, 32'ha5a5_5a5a);
    send_request(KIND_LOOKUP, KEY_ZERO, VAL_EMPTY);
  endtask

  // Zero capacity: with entries, oldest goes and the new one stays; once empty,
  // an insert is dropped at once.
  task automatic test_zero_capacity();
    drain_pipe();
    write_capacity(7'd0);
    send_request(KIND_INSERT, 48'h0f0f_0f0f_0f0f, 32'h0000_0ee0);
    send_request(KIND_REMOVE, 48'h8000_0000_0001, VAL_EMPTY);
    send_request(KIND_REMOVE, 48'h5555_aaaa_5555, VAL_EMPTY);
    send_request(KIND_REMOVE, 48'haaaa_5555_aaaa, VAL_EMPTY);
    send_request(KIND_REMOVE, 48'h0f0f_0f0f_0f0f, VAL_EMPTY);
    send_request(KIND_INSERT, 48'hf0f0_f0f0_f0f0, 32'h0000_0ff0);
    send_request(KIND_LOOKUP, 48'hf0f0_f0f0_f0f0, VAL_EMPTY);
  endtask

  // Mostly well-formed traffic over a small key pool so lookups and removes hit;
  // a few noise words use fresh keys with a random kind, the unused kind included.
  task automatic run_traffic_phase(input logic [CFG_BITS-1:0] limit, input int n_words,
                                   input int pool_n, input int insert_pct);
    logic [KEY_BITS-1:0]      pool[$];
    logic [KIND_BITS-1:0]     kind;
    logic [KEY_BITS-1:0]      key;
    logic [IN_VALUE_BITS-1:0] value;
    int                       roll;
    drain_pipe();
    write_capacity(limit);
    for (int i = 0; i < pool_n; i++) pool.push_back(random_key());
    if (pool_n > 4) begin
      pool[0] = KEY_ZERO;
      pool[1] = KEY_ONES;
    end
    repeat (n_words) begin
      roll  = $urandom_range(0, 99);
      key   = pool[$urandom_range(0, pool_n - 1)];
      value = random_value();
      if (roll < 6) begin
        kind  = KIND_BITS'($urandom_range(0, 3));
        key   = random_key();
        value = $urandom;
      end else if (roll < 6 + insert_pct) begin
        kind = KIND_INSERT;
      end else if (roll < 6 + insert_pct + (94 - insert_pct) * 2 / 3) begin
        kind = KIND_LOOKUP;
      end else begin
        kind = KIND_REMOVE;
      end
      send_request(kind, key, value);
    end
  endtask

  task automatic test_random_traffic();
    int limit;
    run_traffic_phase(7'd127, 120, 100, 70);  // past 64 slots: storage full, clamp
    run_traffic_phase(7'd1, 60, 4, 40);
    limit = $urandom_range(2, 20);
    run_traffic_phase(limit[CFG_BITS-1:0], 100, 2 * limit, 45);
    run_traffic_phase(7'd64, 120, 80, 55);
    run_traffic_phase(7'd0, 40, 4, 40);       // zero capacity on a filled cache
    limit = $urandom_range(1, 127);
    run_traffic_phase(limit[CFG_BITS-1:0], 160,
                      ((limit < CACHE_SLOTS) ? limit : CACHE_SLOTS) + 8, 50);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: segments of free flow, coin-flip stalls, or solid stalls.
  // ---------------------------------------------------------------------------
  int rx_mode = 0;
  int rx_left = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = (rx_mode == 2) ? $urandom_range(1, 120) : $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Checker: each taken result word against the oldest expected reply.
  // ---------------------------------------------------------------------------
  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("%t mismatch: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_replies.size() == 0) begin
        note_failure($sformatf("unexpected word, status %0d found_value %h",
                               out_status, out_found_value));
      end else begin
        taken_reply = expected_replies.pop_front();
        if (out_status !== taken_reply.status)
          note_failure($sformatf("status exp %0d got %0d", taken_reply.status, out_status));
        if (out_found_value !== taken_reply.found)
          note_failure($sformatf("found_value exp %h got %h",
                                 taken_reply.found, out_found_value));
      end
    end
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_requests();
    test_capacity_lowered();
    test_zero_capacity();
    test_random_traffic();
    drain_pipe();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
